[design/sapq_pkg.sv]
`default_nettype none
package sapq_pkg;

	// queue geometry
	localparam int DEPTH = 8;
	localparam int IDX_W = $clog2(DEPTH);

	// item field widths
	localparam int MODE_W  = 2;
	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 8;
	localparam int STAT_W  = 2;
	localparam int OCC_W   = 7;

	// stream widths, padded to whole bytes
	localparam int IN_RAW_W  = MODE_W + VALUE_W + PRIO_W;
	localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_RAW_W = STAT_W + VALUE_W + OCC_W + 2;
	localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

	// one stored entry
	localparam int ENTRY_W = VALUE_W + PRIO_W;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;

	// result status codes
	localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]         prio;
	} entry_t;

endpackage
`default_nettype wire

[design/sorted_array_priority_queue.sv]
`default_nettype none
// Bounded priority queue of sapq_pkg::DEPTH entries, kept sorted by priority in a
// small single-write, single-read memory (read data registered). Each input
// transaction carries a mode (enqueue, dequeue head, query head), a signed value
// and an unsigned priority; each one yields exactly one result transaction with a
// status, the removed or peeked value, the occupancy and the empty/full flags after
// the operation. A new entry lands behind all entries of equal or higher priority.
// Insertion is done by one compare-and-move step a cycle: the sequencer walks from
// the tail toward the head, reading the next entry while it writes the previous one
// one slot up. An enqueue passes through the compare-and-move steps and then an
// insert step before the result is presented; dequeue and query first read the
// head entry; a refused enqueue or an access to an empty queue goes straight to the
// result. s_tready is high only while the sequencer is idle; one result register
// sits on the output so a stalled consumer delays only the next result, not the
// acceptance of the next transaction. Slots freed at the head are reused only after
// the queue has drained completely, so the queue reports full once the tail reaches
// the last slot.
module sorted_array_priority_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// s_tdata, from bit 0: mode[1:0], value[31:0], prio[7:0], zero pad
	input  wire logic [sapq_pkg::IN_W-1:0] s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// m_tdata, from bit 0: status[1:0], data_out[31:0], occupancy[6:0],
	// is_empty, is_full, zero pad
	output logic [sapq_pkg::OUT_W-1:0]  m_tdata
);
	import sapq_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CMP   = 3'd1;
	localparam logic [2:0] S_INS   = 3'd2;
	localparam logic [2:0] S_HDATA = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	// input fields
	logic [MODE_W-1:0]         in_mode;
	logic signed [VALUE_W-1:0] in_value;
	logic [PRIO_W-1:0]         in_prio;

	assign in_mode  = s_tdata[MODE_W-1:0];
	assign in_value = s_tdata[MODE_W +: VALUE_W];
	assign in_prio  = s_tdata[MODE_W+VALUE_W +: PRIO_W];

	// sequencer and queue state
	logic [2:0]         state_q, state_d;
	logic [IDX_W-1:0]   slot_q, slot_d;
	logic [IDX_W-1:0]   head_q, head_d;
	logic [IDX_W-1:0]   tail_q, tail_d;
	logic               empty_q, empty_d;
	logic               deq_q, deq_d;
	entry_t             new_q, new_d;
	logic [STAT_W-1:0]  res_status_q, res_status_d;
	logic signed [VALUE_W-1:0] res_data_q, res_data_d;

	// entry store
	entry_t             mem [DEPTH];
	entry_t             rd_q;
	logic [IDX_W-1:0]   rd_addr;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;

	// output register
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;
	logic               out_load;

	logic               full;
	logic [OCC_W-1:0]   occupancy;
	logic [IDX_W-1:0]   slot_dec;

	assign full      = !empty_q && (tail_q == LAST_IDX);
	assign occupancy = empty_q ? '0 : OCC_W'(tail_q - head_q) + OCC_W'(1);
	assign slot_dec  = slot_q - IDX_W'(1);

	assign s_tready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		state_d      = state_q;
		slot_d       = slot_q;
		head_d       = head_q;
		tail_d       = tail_q;
		empty_d      = empty_q;
		deq_d        = deq_q;
		new_d        = new_q;
		res_status_d = res_status_q;
		res_data_d   = res_data_q;
		rd_addr      = head_q;
		wr_en        = 1'b0;
		wr_addr      = slot_q;
		wr_data      = new_q;

		case (state_q)
			S_IDLE: begin
				// enqueue reads the tail entry, everything else the head entry
				rd_addr = (in_mode == MODE_ENQ) ? tail_q : head_q;
				if (s_tvalid) begin
					new_d.value  = in_value;
					new_d.prio   = in_prio;
					deq_d        = (in_mode == MODE_DEQ);
					res_status_d = STATUS_DONE;
					res_data_d   = '0;
					if (in_mode == MODE_ENQ) begin
						if (full) begin
							res_status_d = STATUS_FULL;
							state_d      = S_DONE;
						end else if (empty_q) begin
							slot_d  = '0;
							state_d = S_INS;
						end else begin
							slot_d  = tail_q + IDX_W'(1);
							state_d = S_CMP;
						end
					end else if (empty_q) begin
						res_status_d = STATUS_EMPTY;
						state_d      = S_DONE;
					end else begin
						state_d = S_HDATA;
					end
				end
			end
			S_CMP: begin
				// rd_q holds the entry at slot_q-1
				if (new_q.prio > rd_q.prio) begin
					// move it up one slot and fetch the next one toward the head
					wr_en   = 1'b1;
					wr_addr = slot_q;
					wr_data = rd_q;
					slot_d  = slot_dec;
					rd_addr = slot_dec - IDX_W'(1);
					if (slot_dec <= head_q) begin
						state_d = S_INS;
					end
				end else begin
					state_d = S_INS;
				end
			end
			S_INS: begin
				wr_en   = 1'b1;
				wr_addr = slot_q;
				wr_data = new_q;
				if (empty_q) begin
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b0;
				end else begin
					tail_d = tail_q + IDX_W'(1);
				end
				state_d = S_DONE;
			end
			S_HDATA: begin
				res_data_d = rd_q.value;
				if (deq_q) begin
					if (head_q == tail_q) begin
						// last entry gone: rewind to slot 0
						head_d  = '0;
						tail_d  = '0;
						empty_d = 1'b1;
					end else begin
						head_d = head_q + IDX_W'(1);
					end
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			empty_q    <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		slot_q       <= slot_d;
		deq_q        <= deq_d;
		new_q        <= new_d;
		res_status_q <= res_status_d;
		res_data_q   <= res_data_d;
		if (out_load) begin
			m_tdata_q <= OUT_W'({full, empty_q, occupancy, res_data_q, res_status_q});
		end
	end

	// entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire
